### rtl/core/bsoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer second-order compensation package
// Widths, constants and calibration register indexes shared by the datapath.
// ----------------------------------------------------------------------------
package bsoc_pkg;

  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 20;
  localparam int PRES_W    = 44;
  localparam int CFG_IDX_W = 3;

  localparam int DT_W      = 25;
  localparam int LIN_W     = 42;
  localparam int DD_W      = 48;
  localparam int A_W       = 18;
  localparam int B_W       = 19;
  localparam int AA_W      = 34;
  localparam int BB_W      = 35;
  localparam int T2_W      = 17;
  localparam int OS_W      = 42;
  localparam int OFF2_W    = 40;
  localparam int SENS2_W   = 39;
  localparam int SPLIT     = 21;
  localparam int PPLO_W    = 45;
  localparam int PPHI_W    = 46;
  localparam int PROD_W    = 67;
  localparam int PIPE_LEN  = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE   = 20'sd2000;
  localparam logic signed [B_W-1:0]    FRIGID_BIAS = 19'sd3500;
  localparam logic [5:0]               OFF2_A_MUL  = 6'd61;
  localparam logic [3:0]               OFF2_B_MUL  = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CAL_C1 = 3'd0,
    CAL_C2 = 3'd1,
    CAL_C3 = 3'd2,
    CAL_C4 = 3'd3,
    CAL_C5 = 3'd4,
    CAL_C6 = 3'd5
  } cfg_idx_t;

endpackage

### rtl/core/baro_second_order_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barometer second-order compensation
// Eight-stage pipeline turning a raw pressure and temperature pair into a
// compensated temperature and a scaled pressure using six calibration words.
// ----------------------------------------------------------------------------
// A transaction is taken in every cycle in which start is high; busy is never
// raised. Each result appears on the out_ ports for one cycle, marked by
// out_valid, and results leave in the order their transactions arrived. The
// pipeline depth is set by the chain of multiplications: the linear terms,
// the squares for the low-temperature correction and the final 24 by 42 bit
// product split into two halves. The receiver cannot stall the block.
// Calibration words are written through the cfg_ port and must only change
// while no transaction is in flight.
module baro_second_order_compensation
  import bsoc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [RAW_W-1:0]           in_raw_pressure,
  input  logic [RAW_W-1:0]           in_raw_temperature,
  output logic                       out_valid,
  output logic signed [TEMP_W-1:0]   out_temperature_centi,
  output logic signed [PRES_W-1:0]   out_pressure_scaled,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CAL_W-1:0]           cfg_wdata
);

  logic [CAL_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;
  logic [PIPE_LEN-1:0] valid_r;
  logic [PIPE_LEN-1:0] valid_nxt;

  // Stage registers.
  logic [RAW_W-1:0]          s1_d1_r;
  logic signed [DT_W-1:0]    s1_dt_r;

  logic [RAW_W-1:0]          s2_d1_r;
  logic signed [LIN_W-1:0]   s2_p6_r, s2_p4_r, s2_p3_r;
  logic [DD_W-1:0]           s2_dd_r;

  logic [RAW_W-1:0]          s3_d1_r;
  logic signed [A_W-1:0]     s3_a_r;
  logic signed [B_W-1:0]     s3_b_r;
  logic signed [OS_W-1:0]    s3_off_r, s3_sens_r;
  logic [T2_W-1:0]           s3_t2_r;

  logic [RAW_W-1:0]          s4_d1_r;
  logic signed [A_W-1:0]     s4_a_r;
  logic [AA_W-1:0]           s4_aa_r;
  logic [BB_W-1:0]           s4_bb_r;
  logic                      s4_cold_r, s4_frigid_r;
  logic signed [OS_W-1:0]    s4_off_r, s4_sens_r;
  logic [T2_W-1:0]           s4_t2_r;

  logic [RAW_W-1:0]          s5_d1_r;
  logic signed [TEMP_W-1:0]  s5_temp_r;
  logic signed [OS_W-1:0]    s5_off_r, s5_sens_r;

  logic signed [TEMP_W-1:0]  s6_temp_r;
  logic signed [OS_W-1:0]    s6_off_r;
  logic [PPLO_W-1:0]         s6_pplo_r;
  logic signed [PPHI_W-1:0]  s6_pphi_r;

  logic signed [TEMP_W-1:0]  s7_temp_r;
  logic signed [OS_W-1:0]    s7_off_r;
  logic signed [PROD_W-1:0]  s7_prod_r;

  logic signed [TEMP_W-1:0]  s8_temp_r;
  logic signed [PRES_W-1:0]  s8_pres_r;

  // Next values.
  logic signed [DT_W-1:0]    s1_dt_nxt;
  logic signed [LIN_W-1:0]   s2_p6_nxt, s2_p4_nxt, s2_p3_nxt;
  logic signed [2*DT_W-1:0]  dd_full;
  logic signed [LIN_W-1:0]   p6_bias, p4_bias, p3_bias;
  logic signed [A_W-1:0]     s3_a_nxt;
  logic signed [B_W-1:0]     s3_b_nxt;
  logic signed [OS_W-1:0]    s3_off_nxt, s3_sens_nxt;
  logic signed [2*A_W-1:0]   aa_full;
  logic signed [2*B_W-1:0]   bb_full;
  logic [OFF2_W-1:0]         aa61, off2;
  logic [SENS2_W-1:0]        sens2;
  logic signed [TEMP_W-1:0]  s5_temp_nxt;
  logic signed [OS_W-1:0]    s5_off_nxt, s5_sens_nxt;
  logic [PPLO_W-1:0]         s6_pplo_nxt;
  logic signed [PPHI_W-1:0]  s6_pphi_nxt;
  logic signed [PROD_W-1:0]  s7_prod_nxt;
  logic signed [PROD_W-1:0]  prod_q, pres_full;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CAL_C1: c1_r <= cfg_wdata;
        CAL_C2: c2_r <= cfg_wdata;
        CAL_C3: c3_r <= cfg_wdata;
        CAL_C4: c4_r <= cfg_wdata;
        CAL_C5: c5_r <= cfg_wdata;
        CAL_C6: c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign valid_nxt = {valid_r[PIPE_LEN-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    s1_dt_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, c5_r, 8'd0});

    s2_p6_nxt = s1_dt_r * $signed({1'b0, c6_r});
    s2_p4_nxt = s1_dt_r * $signed({1'b0, c4_r});
    s2_p3_nxt = s1_dt_r * $signed({1'b0, c3_r});
    dd_full   = s1_dt_r * s1_dt_r;

    // Division by a power of two rounds toward zero: negative values get a
    // bias of the divisor minus one before the arithmetic shift.
    p6_bias     = s2_p6_r + $signed({19'd0, {23{s2_p6_r[LIN_W-1]}}});
    p4_bias     = s2_p4_r + $signed({36'd0, {6{s2_p4_r[LIN_W-1]}}});
    p3_bias     = s2_p3_r + $signed({35'd0, {7{s2_p3_r[LIN_W-1]}}});
    s3_a_nxt    = p6_bias[40:23];
    s3_b_nxt    = B_W'(s3_a_nxt) + FRIGID_BIAS;
    s3_off_nxt  = $signed({9'd0, c2_r, 17'd0}) + (p4_bias >>> 6);
    s3_sens_nxt = $signed({10'd0, c1_r, 16'd0}) + (p3_bias >>> 7);

    aa_full = s3_a_r * s3_a_r;
    bb_full = s3_b_r * s3_b_r;

    aa61  = OFF2_W'(s4_aa_r) * OFF2_W'(OFF2_A_MUL);
    off2  = '0;
    sens2 = '0;
    if (s4_cold_r) begin
      off2  = {4'd0, aa61[OFF2_W-1:4]};
      sens2 = SENS2_W'({s4_aa_r, 1'b0});
      if (s4_frigid_r) begin
        off2  = off2 + OFF2_W'(s4_bb_r) * OFF2_W'(OFF2_B_MUL);
        sens2 = sens2 + SENS2_W'({s4_bb_r, 3'b0});
      end
    end
    s5_temp_nxt = TEMP_BASE + TEMP_W'(s4_a_r)
                - (s4_cold_r ? $signed({3'd0, s4_t2_r}) : $signed(20'd0));
    s5_off_nxt  = s4_off_r - $signed({2'd0, off2});
    s5_sens_nxt = s4_sens_r - $signed({3'd0, sens2});

    s6_pplo_nxt = PPLO_W'(s5_d1_r) * PPLO_W'(s5_sens_r[SPLIT-1:0]);
    s6_pphi_nxt = $signed({1'b0, s5_d1_r}) * $signed(s5_sens_r[OS_W-1:SPLIT]);

    s7_prod_nxt = (PROD_W'(s6_pphi_r) <<< SPLIT) + $signed({22'd0, s6_pplo_r});

    prod_q    = (s7_prod_r + $signed({46'd0, {21{s7_prod_r[PROD_W-1]}}})) >>> SPLIT;
    pres_full = prod_q - PROD_W'(s7_off_r);
  end

  always_ff @(posedge clk) begin
    s1_d1_r     <= in_raw_pressure;
    s1_dt_r     <= s1_dt_nxt;

    s2_d1_r     <= s1_d1_r;
    s2_p6_r     <= s2_p6_nxt;
    s2_p4_r     <= s2_p4_nxt;
    s2_p3_r     <= s2_p3_nxt;
    s2_dd_r     <= dd_full[DD_W-1:0];

    s3_d1_r     <= s2_d1_r;
    s3_a_r      <= s3_a_nxt;
    s3_b_r      <= s3_b_nxt;
    s3_off_r    <= s3_off_nxt;
    s3_sens_r   <= s3_sens_nxt;
    s3_t2_r     <= s2_dd_r[DD_W-1:31];

    s4_d1_r     <= s3_d1_r;
    s4_a_r      <= s3_a_r;
    s4_aa_r     <= aa_full[AA_W-1:0];
    s4_bb_r     <= bb_full[BB_W-1:0];
    s4_cold_r   <= s3_a_r[A_W-1];
    s4_frigid_r <= s3_b_r[B_W-1];
    s4_off_r    <= s3_off_r;
    s4_sens_r   <= s3_sens_r;
    s4_t2_r     <= s3_t2_r;

    s5_d1_r     <= s4_d1_r;
    s5_temp_r   <= s5_temp_nxt;
    s5_off_r    <= s5_off_nxt;
    s5_sens_r   <= s5_sens_nxt;

    s6_temp_r   <= s5_temp_r;
    s6_off_r    <= s5_off_r;
    s6_pplo_r   <= s6_pplo_nxt;
    s6_pphi_r   <= s6_pphi_nxt;

    s7_temp_r   <= s6_temp_r;
    s7_off_r    <= s6_off_r;
    s7_prod_r   <= s7_prod_nxt;

    s8_temp_r   <= s7_temp_r;
    s8_pres_r   <= pres_full[PRES_W-1:0];
  end

  assign out_valid             = valid_r[PIPE_LEN-1];
  assign out_temperature_centi = s8_temp_r;
  assign out_pressure_scaled   = s8_pres_r;

endmodule
